// ----- hdl/sfla_pkg.sv -----
package sfla_pkg;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_BLOCK_BYTES_DEF = 64;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_CLASS = 2'd2;

  localparam logic CMD_REBUILD = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BUILD, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_FETCH, ST_MOVE, ST_DONE
  } sfla_state_t;

  typedef struct packed {
    logic build_start;
    logic build_step;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic fetch_last;
    logic move_last;
    logic clear_result;
  } sfla_cmd_t;

  typedef struct packed {
    logic build_done;
    logic scan_done;
    logic found;
    logic exact;
  } sfla_stat_t;
endpackage

// ----- hdl/sfla_if.sv -----
interface sfla_in_if;
  import sfla_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  logic [SIZE_W-1:0] request_size;
  modport source (output valid, cmd, request_size, input ready);
  modport sink (input valid, cmd, request_size, output ready);
endinterface

interface sfla_out_if;
  import sfla_pkg::*;
  logic valid;
  logic ready;
  logic granted;
  logic [ADDR_W-1:0] block_address;
  logic was_split;
  logic [31:0] split_total;
  modport source (output valid, granted, block_address, was_split, split_total, input ready);
  modport sink (input valid, granted, block_address, was_split, split_total, output ready);
endinterface

// ----- hdl/sfla_datapath.sv -----
module sfla_datapath import sfla_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  sfla_cmd_t cmd_i,
  output sfla_stat_t stat_o,
  input  logic [ADDR_W-1:0] heap_base_i,
  input  logic [2:0] class_count_i,
  input  logic [12:0] bytes_per_class_i,
  input  logic [SIZE_W-1:0] req_i,
  output logic granted_o,
  output logic [ADDR_W-1:0] address_o,
  output logic was_split_o,
  output logic [31:0] split_total_o
);
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int BSZ_W = $clog2(MAX_BLOCK_BYTES + 1);

  logic [ADDR_W-1:0] addr_mem [STORE_DEPTH];
  logic [BSZ_W-1:0] size_mem [STORE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] splits_r, splits_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] rd_idx;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [BSZ_W-1:0] rd_size_r;
  logic rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_pos_r;
  logic found_r, found_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [ADDR_W-1:0] best_addr_r, best_addr_nxt;
  logic [BSZ_W-1:0] best_size_r, best_size_nxt;
  logic [ADDR_W-1:0] bld_addr_r, bld_addr_nxt;
  logic [10:0] bld_size_r, bld_size_nxt;
  logic [12:0] bld_left_r, bld_left_nxt;
  logic [10:0] largest;
  logic bld_ok;
  logic granted_r, granted_nxt;
  logic [ADDR_W-1:0] address_r, address_nxt;
  logic split_r, split_nxt;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [BSZ_W-1:0] wr_size;
  logic take;

  assign largest = 11'd1 << ({1'b0, class_count_i} + 4'd2);
  assign bld_ok = (bld_size_r <= largest) && (32'(bld_size_r) <= 32'(MAX_BLOCK_BYTES))
                  && (bld_size_r != 11'd0);

  always_comb begin
    rd_idx = ptr_r[IDX_W-1:0];
    if (cmd_i.fetch_last) rd_idx = count_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= addr_mem[rd_idx];
    rd_size_r <= size_mem[rd_idx];
    rd_pos_r <= rd_idx;
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_addr;
      size_mem[wr_idx] <= wr_size;
    end
  end

  always_comb begin
    take = 1'b0;
    if (rd_vld_r && 17'(rd_size_r) >= 17'(req_i)) begin
      if (!found_r || rd_size_r < best_size_r ||
          (rd_size_r == best_size_r && rd_addr_r < best_addr_r)) take = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    splits_nxt = splits_r;
    ptr_nxt = ptr_r;
    rd_vld_nxt = 1'b0;
    found_nxt = found_r;
    best_nxt = best_r;
    best_addr_nxt = best_addr_r;
    best_size_nxt = best_size_r;
    bld_addr_nxt = bld_addr_r;
    bld_size_nxt = bld_size_r;
    bld_left_nxt = bld_left_r;
    granted_nxt = granted_r;
    address_nxt = address_r;
    split_nxt = split_r;
    wr_en = 1'b0;
    wr_idx = count_r[IDX_W-1:0];
    wr_addr = bld_addr_r;
    wr_size = BSZ_W'(bld_size_r);
    stat_o.build_done = 1'b0;
    stat_o.scan_done = cmd_i.scan_step && (ptr_r >= count_r) && !rd_vld_r;
    stat_o.found = found_r;
    stat_o.exact = (17'(best_size_r) == 17'(req_i));
    if (cmd_i.clear_result) begin
      granted_nxt = 1'b0;
      address_nxt = '0;
      split_nxt = 1'b0;
    end
    if (cmd_i.build_start) begin
      count_nxt = '0;
      splits_nxt = '0;
      bld_addr_nxt = heap_base_i;
      bld_size_nxt = 11'd8;
      bld_left_nxt = bytes_per_class_i;
    end
    if (cmd_i.build_step) begin
      if (!bld_ok || count_r >= CNT_W'(STORE_DEPTH)) begin
        stat_o.build_done = 1'b1;
        granted_nxt = 1'b1;
      end else if (bld_left_r < 13'(bld_size_r)) begin
        bld_size_nxt = bld_size_r << 1;
        bld_left_nxt = bytes_per_class_i;
      end else begin
        wr_en = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        bld_addr_nxt = bld_addr_r + ADDR_W'(bld_size_r);
        bld_left_nxt = bld_left_r - 13'(bld_size_r);
      end
    end
    if (cmd_i.scan_start) begin
      ptr_nxt = '0;
      found_nxt = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (ptr_r < count_r) begin
        rd_vld_nxt = 1'b1;
        ptr_nxt = ptr_r + CNT_W'(1);
      end
      if (take) begin
        found_nxt = 1'b1;
        best_nxt = rd_pos_r;
        best_addr_nxt = rd_addr_r;
        best_size_nxt = rd_size_r;
      end
    end
    if (cmd_i.commit) begin
      granted_nxt = 1'b1;
      address_nxt = best_addr_r;
      if (17'(best_size_r) == 17'(req_i)) begin
        count_nxt = count_r - CNT_W'(1);
      end else begin
        wr_en = 1'b1;
        wr_idx = best_r;
        wr_addr = best_addr_r + ADDR_W'(req_i);
        wr_size = best_size_r - BSZ_W'(req_i);
        split_nxt = 1'b1;
        splits_nxt = splits_r + 32'd1;
      end
    end
    if (cmd_i.move_last) begin
      wr_en = 1'b1;
      wr_idx = best_r;
      wr_addr = rd_addr_r;
      wr_size = rd_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      splits_r <= '0;
      ptr_r <= '0;
      rd_vld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      splits_r <= splits_nxt;
      ptr_r <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    best_addr_r <= best_addr_nxt;
    best_size_r <= best_size_nxt;
    bld_addr_r <= bld_addr_nxt;
    bld_size_r <= bld_size_nxt;
    bld_left_r <= bld_left_nxt;
    granted_r <= granted_nxt;
    address_r <= address_nxt;
    split_r <= split_nxt;
  end

  assign granted_o = granted_r;
  assign address_o = address_r;
  assign was_split_o = split_r;
  assign split_total_o = splits_r;
endmodule

// ----- hdl/sfla_ctrl.sv -----
module sfla_ctrl import sfla_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_cmd,
  input  logic req_zero,
  input  logic out_fire,
  input  sfla_stat_t stat_i,
  output sfla_cmd_t cmd_o,
  output logic in_ready,
  output logic out_valid
);
  sfla_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd_o.clear_result = 1'b1;
          if (in_cmd == CMD_REBUILD) begin
            cmd_o.build_start = 1'b1;
            state_nxt = ST_BUILD;
          end else if (req_zero) begin
            state_nxt = ST_DONE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_BUILD: begin
        cmd_o.build_step = 1'b1;
        if (stat_i.build_done) state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat_i.found) state_nxt = ST_COMMIT;
        else state_nxt = ST_DONE;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (stat_i.exact) state_nxt = ST_FETCH;
        else state_nxt = ST_DONE;
      end
      ST_FETCH: begin
        cmd_o.fetch_last = 1'b1;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move_last = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- hdl/segregated_free_list_allocator.sv -----
// channel | direction | payload
// in      | sink      | cmd, request_size
// out     | source    | granted, block_address, was_split, split_total
// cfg     | write     | cfg_we, cfg_index, cfg_data
// rebuild: places blocks class by class from 8 bytes up, doubling the size when a class's bytes run out
// allocate: scans every stored entry through the single store read port
// one item at a time; the result register holds until its transfer
// reset is synchronous; store contents are undefined until a rebuild
module segregated_free_list_allocator import sfla_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfla_in_if.sink in_ch,
  sfla_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  logic [ADDR_W-1:0] heap_base_r;
  logic [2:0] class_count_r;
  logic [12:0] bytes_per_class_r;
  logic [SIZE_W-1:0] req_r;
  sfla_cmd_t cmd;
  sfla_stat_t stat;
  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= 32'h0100_0000;
      class_count_r <= 3'd4;
      bytes_per_class_r <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE: heap_base_r <= cfg_data;
        REG_CLASS_COUNT: class_count_r <= cfg_data[2:0];
        REG_BYTES_PER_CLASS: bytes_per_class_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_ch.request_size;
  end

  sfla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_ch.cmd),
    .req_zero(in_ch.request_size == '0), .out_fire(out_ch.valid && out_ch.ready),
    .stat_i(stat), .cmd_o(cmd), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
  );

  sfla_datapath #(.STORE_DEPTH(STORE_DEPTH), .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd_i(cmd), .stat_o(stat),
    .heap_base_i(heap_base_r), .class_count_i(class_count_r),
    .bytes_per_class_i(bytes_per_class_r), .req_i(req_r),
    .granted_o(out_ch.granted), .address_o(out_ch.block_address),
    .was_split_o(out_ch.was_split), .split_total_o(out_ch.split_total)
  );
endmodule

// ----- hdl/sfla_checker.sv -----
module sfla_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic granted,
  input logic [31:0] block_address,
  input logic was_split
);
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !granted |-> block_address == 32'd0 && !was_split)
    else $error("failed result not clean");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(block_address))
    else $error("result dropped");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input taken while busy");
endmodule

bind segregated_free_list_allocator sfla_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .granted(out_ch.granted),
  .block_address(out_ch.block_address), .was_split(out_ch.was_split)
);
